// ----- sv/pwsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pwsa_pkg: shared types and constants of the wind speed alarm
// Field widths, register indexes and the control structs between the top
// level and the serial arithmetic unit.
// ----------------------------------------------------------------------------
package pwsa_pkg;

  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 32;
  localparam int SPEED_W  = 24;
  localparam int FACTOR_W = 16;
  localparam int IVAL_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // factor * 1000 is 26 bits wide, the product with the pulse delta 58 bits
  localparam int MS_PER_S = 1000;
  localparam int KMUL_W   = FACTOR_W + 10;
  localparam int PROD_W   = COUNT_W + KMUL_W;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_IVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHK_IVAL  = 2'd3;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd256;
  localparam logic [IVAL_W-1:0]   IVAL_RST   = 16'd1000;

  typedef struct packed {
    logic                start;
    logic [COUNT_W-1:0]  delta;
    logic [FACTOR_W-1:0] factor;
    logic [TIME_W-1:0]   elapsed;
  } calc_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SPEED_W-1:0] speed;
  } calc_sts_t;

endpackage

// ----- sv/pwsa_if.sv -----
// ----------------------------------------------------------------------------
// pwsa_if: valid/ready channels of the wind speed alarm
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface pwsa_in_if import pwsa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  now_ms;
  logic [COUNT_W-1:0] pulse_count;

  modport source (output valid, now_ms, pulse_count, input ready);
  modport sink   (input valid, now_ms, pulse_count, output ready);
endinterface

interface pwsa_out_if import pwsa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;
  logic               measured;
  logic               alarm;
  logic               alarm_rise;

  modport source (output valid, speed, measured, alarm, alarm_rise, input ready);
  modport sink   (input valid, speed, measured, alarm, alarm_rise, output ready);
endinterface

interface pwsa_cfg_if import pwsa_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/pwsa_calc.sv -----
// ----------------------------------------------------------------------------
// pwsa_calc: bit-serial speed calculation
// Shift-add multiply of delta by factor*1000, then a restoring divide by the
// elapsed time, one quotient bit per cycle, saturated to the speed width.
// ----------------------------------------------------------------------------
module pwsa_calc import pwsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  calc_cmd_t cmd,
  output calc_sts_t sts
);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_CHK  = 5'b00100,
    U_DIV  = 5'b01000,
    U_DONE = 5'b10000
  } ustate_t;

  localparam logic [4:0] MUL_LAST = 5'(KMUL_W - 1);
  localparam logic [4:0] DIV_LAST = 5'(SPEED_W - 1);

  ustate_t             state_r, state_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]  hi_r, hi_nxt;
  logic [KMUL_W-1:0]   lo_r, lo_nxt;
  logic [COUNT_W-1:0]  dl_r, dl_nxt;
  logic [TIME_W-1:0]   el_r, el_nxt;
  logic [SPEED_W-1:0]  res_r, res_nxt;

  logic [COUNT_W:0]    mul_sum;
  logic [COUNT_W+1:0]  quo_top;
  logic [TIME_W:0]     div_part;
  logic [TIME_W:0]     div_diff;
  logic                div_ge;
  logic [KMUL_W-1:0]   kmul;

  always_comb begin
    kmul     = KMUL_W'(cmd.factor) * KMUL_W'(MS_PER_S);
    mul_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, dl_r} : '0);
    quo_top  = {hi_r, lo_r[KMUL_W-1:SPEED_W]};
    div_part = {hi_r, lo_r[SPEED_W-1]};
    div_ge   = div_part >= {1'b0, el_r};
    div_diff = div_part - {1'b0, el_r};

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    dl_nxt    = dl_r;
    el_nxt    = el_r;
    res_nxt   = res_r;

    unique case (state_r)
      U_IDLE: begin
        if (cmd.start) begin
          hi_nxt    = '0;
          lo_nxt    = kmul;
          dl_nxt    = cmd.delta;
          el_nxt    = cmd.elapsed;
          cnt_nxt   = '0;
          state_nxt = U_MUL;
        end
      end
      U_MUL: begin
        hi_nxt  = mul_sum[COUNT_W:1];
        lo_nxt  = {mul_sum[0], lo_r[KMUL_W-1:1]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = U_CHK;
        end
      end
      U_CHK: begin
        // a quotient of 2^24 or more shows up in the top product bits alone
        if (!(|{hi_r, lo_r})) begin
          res_nxt   = '0;
          state_nxt = U_DONE;
        end else if (quo_top >= {2'b00, el_r}) begin
          res_nxt   = SPEED_MAX;
          state_nxt = U_DONE;
        end else begin
          hi_nxt    = quo_top[TIME_W-1:0];
          cnt_nxt   = '0;
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        hi_nxt              = div_ge ? div_diff[TIME_W-1:0] : div_part[TIME_W-1:0];
        lo_nxt[SPEED_W-1:0] = {lo_r[SPEED_W-2:0], div_ge};
        cnt_nxt             = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          res_nxt   = {lo_r[SPEED_W-2:0], div_ge};
          state_nxt = U_DONE;
        end
      end
      U_DONE: begin
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    dl_r  <= dl_nxt;
    el_r  <= el_nxt;
    res_r <= res_nxt;
  end

  assign sts.busy  = (state_r != U_IDLE);
  assign sts.done  = (state_r == U_DONE);
  assign sts.speed = res_r;

  a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_DONE) |-> ($past(state_r) == U_CHK || $past(state_r) == U_DIV))
    else $error("calc done without a check or divide step");

  a_mul_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_CHK) |-> ($past(state_r) == U_MUL && $past(cnt_r) == MUL_LAST))
    else $error("multiply left early");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_IDLE && cmd.start) |=> (state_r == U_MUL && cnt_r == 5'd0))
    else $error("start not taken");

endmodule

// ----- sv/pulse_rate_wind_speed_alarm.sv -----
// ----------------------------------------------------------------------------
// pulse_rate_wind_speed_alarm: anemometer pulse-rate meter with alarm
// Measures wind speed from timestamped pulse counts and raises a threshold
// alarm, one result beat per sample beat.
// ----------------------------------------------------------------------------
// Each sample beat yields exactly one result beat. A sample that triggers a
// measurement runs a shift-add multiply of the pulse delta by factor*1000
// and a restoring divide by the elapsed milliseconds, both in the serial calc
// unit. When the product is zero or the quotient saturates, the divide is
// skipped. A sample with no measurement due goes straight to the finish
// state. A stalled result beat holds back the finish of the next sample. One
// sample is in work at a time; a finished result waits in the output register
// while the next sample is taken. Register writes are accepted at any time
// but must only be issued while no sample is in work.
module pulse_rate_wind_speed_alarm import pwsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pwsa_in_if.sink     in_ch,
  pwsa_out_if.source  out_ch,
  pwsa_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CALC = 3'b010,
    T_FIN  = 3'b100
  } tstate_t;

  tstate_t             state_r, state_nxt;

  logic [SPEED_W-1:0]  thr_r;
  logic [FACTOR_W-1:0] factor_r;
  logic [IVAL_W-1:0]   meas_ival_r;
  logic [IVAL_W-1:0]   chk_ival_r;

  logic [COUNT_W-1:0]  prev_pulses_r;
  logic [TIME_W-1:0]   prev_meas_r;
  logic [TIME_W-1:0]   prev_chk_r;
  logic [SPEED_W-1:0]  speed_now_r;
  logic                alarm_r;

  logic [TIME_W-1:0]   now_r;
  logic [COUNT_W-1:0]  pulses_r;
  logic                meas_r, chk_r;
  logic [SPEED_W-1:0]  new_speed_r;

  logic                out_valid_r;
  logic [SPEED_W-1:0]  out_speed_r;
  logic                out_meas_r, out_alarm_r, out_rise_r;

  logic                in_fire, cfg_fire, fin_go, over;
  logic [TIME_W-1:0]   meas_elapsed, chk_elapsed;
  calc_cmd_t           cmd;
  calc_sts_t           sts;

  assign in_ch.ready  = (state_r == T_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign fin_go       = (state_r == T_FIN) && (!out_valid_r || out_ch.ready);

  assign meas_elapsed = in_ch.now_ms - prev_meas_r;
  assign chk_elapsed  = in_ch.now_ms - prev_chk_r;
  assign over         = (thr_r != '0) && (new_speed_r > thr_r);

  assign cmd.start   = in_fire && (meas_elapsed >= TIME_W'(meas_ival_r));
  assign cmd.delta   = in_ch.pulse_count - prev_pulses_r;
  assign cmd.factor  = factor_r;
  assign cmd.elapsed = meas_elapsed;

  pwsa_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (in_fire) state_nxt = cmd.start ? T_CALC : T_FIN;
      T_CALC: if (sts.done) state_nxt = T_FIN;
      T_FIN:  if (fin_go) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      thr_r         <= '0;
      factor_r      <= FACTOR_RST;
      meas_ival_r   <= IVAL_RST;
      chk_ival_r    <= IVAL_RST;
      prev_pulses_r <= '0;
      prev_meas_r   <= '0;
      prev_chk_r    <= '0;
      speed_now_r   <= '0;
      alarm_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        unique case (cfg_ch.index)
          REG_THRESHOLD: thr_r       <= cfg_ch.data;
          REG_FACTOR:    factor_r    <= cfg_ch.data[FACTOR_W-1:0];
          REG_MEAS_IVAL: meas_ival_r <= cfg_ch.data[IVAL_W-1:0];
          REG_CHK_IVAL:  chk_ival_r  <= cfg_ch.data[IVAL_W-1:0];
          default: ;
        endcase
      end
      // load on a finished item, hold until the beat is taken
      out_valid_r <= fin_go || (out_valid_r && !out_ch.ready);
      // commit the item state
      if (fin_go) begin
        speed_now_r <= new_speed_r;
        if (meas_r) begin
          prev_pulses_r <= pulses_r;
          prev_meas_r   <= now_r;
        end
        if (chk_r) begin
          prev_chk_r <= now_r;
          alarm_r    <= over;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r       <= in_ch.now_ms;
      pulses_r    <= in_ch.pulse_count;
      meas_r      <= cmd.start;
      chk_r       <= chk_elapsed >= TIME_W'(chk_ival_r);
      new_speed_r <= speed_now_r;
    end else if (state_r == T_CALC && sts.done) begin
      new_speed_r <= sts.speed;
    end
    if (fin_go) begin
      out_speed_r <= new_speed_r;
      out_meas_r  <= meas_r;
      out_alarm_r <= chk_r ? over : alarm_r;
      out_rise_r  <= chk_r && over && !alarm_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.speed      = out_speed_r;
  assign out_ch.measured   = out_meas_r;
  assign out_ch.alarm      = out_alarm_r;
  assign out_ch.alarm_rise = out_rise_r;

  a_rise_sets_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rise_r) |-> out_alarm_r)
    else $error("alarm rise without alarm");

  a_calc_only_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == T_CALC))
    else $error("calc result outside the calc state");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == T_FIN))
    else $error("result beat without a finished item");

  a_unmeasured_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && !meas_r) |-> (new_speed_r == speed_now_r))
    else $error("speed changed without a measurement");

  a_calc_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !sts.busy)
    else $error("sample beat offered while calc busy");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: wind speed meter and alarm, self-checking
// Drives timestamped pulse-count samples and register writes through the
// valid/ready channels and predicts every result beat in the bench. Speed,
// measurement flag, alarm and alarm edge are checked on every beat. Random
// gaps and stalls fall on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import pwsa_pkg::*;

  localparam int SPEED_FRAC    = 8;
  localparam int FACTOR_FRAC   = 8;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_BEATS   = 86;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int MAX_PRINTS    = 40;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [COUNT_W-1:0] pulses;
  } sample_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               measured;
    logic               alarm;
    logic               alarm_rise;
  } wind_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // bench-side drivers of the block inputs, known from time zero
  logic                  smp_valid  = 1'b0;
  logic [TIME_W-1:0]     smp_now    = '0;
  logic [COUNT_W-1:0]    smp_pulses = '0;
  logic                  res_ready  = 1'b0;
  logic                  reg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  reg_index  = '0;
  logic [CFG_DATA_W-1:0] reg_data   = '0;

  pwsa_in_if  in_ch();
  pwsa_out_if out_ch();
  pwsa_cfg_if cfg_ch();

  assign in_ch.valid       = smp_valid;
  assign in_ch.now_ms      = smp_now;
  assign in_ch.pulse_count = smp_pulses;
  assign out_ch.ready      = res_ready;
  assign cfg_ch.valid      = reg_valid;
  assign cfg_ch.index      = reg_index;
  assign cfg_ch.data       = reg_data;

  pulse_rate_wind_speed_alarm uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register shadow
  logic [SPEED_W-1:0]  thr_reg    = '0;
  logic [FACTOR_W-1:0] factor_reg = FACTOR_RST;
  logic [IVAL_W-1:0]   meas_ival  = IVAL_RST;
  logic [IVAL_W-1:0]   chk_ival   = IVAL_RST;

  // meter state as predicted
  logic [COUNT_W-1:0] last_pulses  = '0;
  logic [TIME_W-1:0]  last_meas_ms = '0;
  logic [TIME_W-1:0]  last_chk_ms  = '0;
  logic [SPEED_W-1:0] cur_speed    = '0;
  logic               alarm_on     = 1'b0;

  sample_t      sample_q[$];
  wind_result_t result_q[$];
  sample_t      nxt_smp;
  wind_result_t want_res;

  int unsigned samples_owed = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned smp_gap      = 0;
  int unsigned res_stall    = 0;
  bit          quiet        = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [IVAL_W-1:0] pick_interval();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return IVAL_W'(1);
      2:       return '1;
      3, 4:    return IVAL_W'($urandom_range(2, 20));
      default: return IVAL_W'($urandom_range(21, 2000));
    endcase
  endfunction

  // floor(delta * 1000 * factor * 2^SPEED_FRAC / (elapsed * 2^FACTOR_FRAC)), saturated
  function automatic logic [SPEED_W-1:0] wind_speed(input logic [COUNT_W-1:0] delta,
                                                    input logic [TIME_W-1:0] elapsed);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] res;
    if (elapsed == '0) return (delta != '0 && factor_reg != '0) ? SPEED_MAX : '0;
    num = 64'(delta) * 64'(MS_PER_S) * 64'(factor_reg);
    den = 64'(elapsed) << FACTOR_FRAC;
    quo = num / den;
    rem = num % den;
    if (quo > 64'(SPEED_MAX)) return SPEED_MAX;
    res = (quo << SPEED_FRAC) + ((rem << SPEED_FRAC) / den);
    if (res > 64'(SPEED_MAX)) res = 64'(SPEED_MAX);
    return res[SPEED_W-1:0];
  endfunction

  // measure first, then check the alarm against the fresh speed
  function automatic wind_result_t wind_step(input sample_t s);
    wind_result_t r;
    logic [TIME_W-1:0] since_meas;
    logic [TIME_W-1:0] since_chk;
    logic              over;
    r = '0;
    since_meas = s.now_ms - last_meas_ms;
    since_chk  = s.now_ms - last_chk_ms;
    if (since_meas >= TIME_W'(meas_ival)) begin
      cur_speed    = wind_speed(s.pulses - last_pulses, since_meas);
      last_pulses  = s.pulses;
      last_meas_ms = s.now_ms;
      r.measured   = 1'b1;
    end
    if (since_chk >= TIME_W'(chk_ival)) begin
      over         = (thr_reg != '0) && (cur_speed > thr_reg);
      last_chk_ms  = s.now_ms;
      r.alarm_rise = over && !alarm_on;
      alarm_on     = over;
    end
    r.speed = cur_speed;
    r.alarm = alarm_on;
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (err_cnt < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d: %s got 0x%0h, want 0x%0h",
                             results_seen, name, got, want));
  endtask

  task automatic queue_sample(input logic [TIME_W-1:0] now_ms,
                              input logic [COUNT_W-1:0] pulses);
    sample_q.push_back(sample_t'{now_ms, pulses});
    samples_owed++;
  endtask

  // wait until every sample is taken and every result has come back
  task automatic drain_results();
    @(posedge clk);
    while (samples_owed != 0 || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    reg_valid <= 1'b1;
    reg_index <= idx;
    reg_data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_valid <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_reg    = val[SPEED_W-1:0];
      REG_FACTOR:    factor_reg = val[FACTOR_W-1:0];
      REG_MEAS_IVAL: meas_ival  = val[IVAL_W-1:0];
      REG_CHK_IVAL:  chk_ival   = val[IVAL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // sample driver: take a beat from the queue once the previous one is gone
  always @(posedge clk) begin
    if (!rst_n) begin
      smp_valid <= 1'b0;
      smp_gap = 0;
    end else begin
      if (smp_valid && in_ch.ready) begin
        result_q.push_back(wind_step(sample_t'{smp_now, smp_pulses}));
        samples_owed--;
      end
      if (!smp_valid || in_ch.ready) begin
        if (smp_gap != 0) begin
          smp_gap--;
          smp_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          nxt_smp = sample_q.pop_front();
          smp_valid  <= 1'b1;
          smp_now    <= nxt_smp.now_ms;
          smp_pulses <= nxt_smp.pulses;
          smp_gap = pick_gap();
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      res_stall = 0;
    end else begin
      if (out_ch.valid && res_ready) begin
        if (result_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with no sample pending", results_seen));
        end else begin
          want_res = result_q.pop_front();
          check_field("speed", 32'(out_ch.speed), 32'(want_res.speed));
          check_field("measured", 32'(out_ch.measured), 32'(want_res.measured));
          check_field("alarm", 32'(out_ch.alarm), 32'(want_res.alarm));
          check_field("alarm_rise", 32'(out_ch.alarm_rise), 32'(want_res.alarm_rise));
        end
        results_seen++;
      end
      if (res_stall != 0) begin
        res_stall--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        res_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results seen", cycle_cnt, results_seen);
      $display("pulse_rate_wind_speed_alarm test failed");
      $finish;
    end
  end

  initial begin
    int unsigned           rate_lo;
    int unsigned           rate_hi;
    int unsigned           span;
    int unsigned           step;
    int unsigned           kind;
    int unsigned           fval;
    logic [63:0]           thr_wide;
    logic [CFG_DATA_W-1:0] thr_val;
    logic [TIME_W-1:0]     t_ms;
    logic [COUNT_W-1:0]    p_cnt;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings first
    queue_sample(32'd0, 32'd0);
    queue_sample(32'd1000, 32'd250);
    drain_results();
    write_reg(REG_THRESHOLD, 24'd1000);
    queue_sample(32'd2000, 32'd500);
    queue_sample(32'd2500, 32'd600);
    drain_results();

    // max factor and threshold, measure and check on every beat
    write_reg(REG_FACTOR, 24'h00FFFF);
    write_reg(REG_THRESHOLD, 24'hFFFFFF);
    write_reg(REG_MEAS_IVAL, 24'd0);
    write_reg(REG_CHK_IVAL, 24'd0);
    queue_sample(32'd2500, 32'd600);
    queue_sample(32'd2500, 32'hFFFF_FFFF);
    queue_sample(32'd2501, 32'd5);
    drain_results();
    write_reg(REG_THRESHOLD, 24'd1);
    queue_sample(32'hFFFF_FFFF, 32'd100);
    queue_sample(32'd16, 32'd100);
    drain_results();

    // upper data bits are dropped, leaving a zero factor
    write_reg(REG_FACTOR, 24'hFF0000);
    queue_sample(32'd100, 32'd5000);
    queue_sample(32'd100, 32'd9000);
    drain_results();
    write_reg(REG_FACTOR, 24'd1);
    write_reg(REG_MEAS_IVAL, 24'h00FFFF);
    write_reg(REG_CHK_IVAL, 24'h00FFFF);
    queue_sample(32'd65634, 32'd9000);
    queue_sample(32'd65635, 32'hFFFF_FFFF);
    queue_sample(32'hFFFF_FFFF, 32'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      quiet = (ph % 4 == 3);

      kind = $urandom_range(0, 19);
      if (ph == 0)                   fval = 16'hFFFF;
      else if (ph == NUM_PHASES - 1) fval = 1;
      else if (kind == 0)            fval = 0;
      else if (kind == 1)            fval = 16'hFFFF;
      else                           fval = $urandom_range(16, 1024);
      write_reg(REG_FACTOR, {8'($urandom), 16'(fval)});

      // aim the threshold at the middle of this phase's pulse rates
      rate_lo = $urandom_range(0, 150);
      rate_hi = rate_lo + $urandom_range(0, 150);
      thr_wide = 64'((rate_lo + rate_hi) / 2) * 64'(fval);
      kind = $urandom_range(0, 19);
      if (kind == 0)                  thr_val = '0;
      else if (kind == 1 || ph == 0)  thr_val = '1;
      else if (kind == 2)             thr_val = 24'd1;
      else if (thr_wide > 64'(SPEED_MAX)) thr_val = SPEED_MAX;
      else                            thr_val = thr_wide[CFG_DATA_W-1:0];
      write_reg(REG_THRESHOLD, thr_val);

      write_reg(REG_MEAS_IVAL, CFG_DATA_W'(pick_interval()));
      write_reg(REG_CHK_IVAL, CFG_DATA_W'(pick_interval()));

      span = (meas_ival > chk_ival) ? meas_ival : chk_ival;
      if (span == 0) span = 1;
      t_ms  = $urandom;
      p_cnt = $urandom;
      repeat (PHASE_BEATS) begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          step = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 2 * span);
          t_ms  = t_ms + step;
          p_cnt = p_cnt + COUNT_W'((64'(step) * 64'($urandom_range(rate_lo, rate_hi)))
                                   / MS_PER_S);
        end else if (kind < 90) begin
          // pulse burst: huge delta over a few ms
          t_ms  = t_ms + $urandom_range(0, 3);
          p_cnt = p_cnt + $urandom;
        end else begin
          t_ms  = $urandom;
          p_cnt = $urandom;
        end
        queue_sample(t_ms, p_cnt);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (result_q.size() != 0)
      report_error($sformatf("%0d results never arrived", result_q.size()));
    if (err_cnt == 0) begin
      $display("pulse_rate_wind_speed_alarm test passed");
    end else begin
      $display("pulse_rate_wind_speed_alarm test failed");
    end
    $finish;
  end

endmodule
